/* sv/omsn_pkg.sv */
`default_nettype none
package omsn_pkg;
    localparam int NODES_DEF = 5;
    localparam int SEMS_DEF = 10;
    localparam int QDEPTH_DEF = 64;

    localparam logic [2:0] REQ_ACK = 3'd0;
    localparam logic [2:0] REQ_P = 3'd1;
    localparam logic [2:0] REQ_V = 3'd2;
    localparam logic [2:0] REQ_RP = 3'd3;
    localparam logic [2:0] REQ_RV = 3'd4;

    localparam logic [1:0] OP_ACK = 2'd0;
    localparam logic [1:0] OP_P = 2'd1;
    localparam logic [1:0] OP_V = 2'd2;

    localparam logic [1:0] ADDR_NODE_ID = 2'd0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  sender_id;
        logic [31:0] msg_time;
        logic [3:0]  sem_index;
    } in_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [1:0]  out_op;
        logic [2:0]  out_sender;
        logic [31:0] out_time;
        logic [3:0]  out_sem;
        logic [6:0]  grant_count;
        logic        queue_overflow;
    } out_item_t;

    // queue entry: sender, stamp, op, sem
    typedef struct packed {
        logic [2:0]  sender;
        logic [31:0] stamp;
        logic [1:0]  op;
        logic [3:0]  sem;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_RD,
        ST_INS_WR,
        ST_MIN,
        ST_V_RD,
        ST_V_EX,
        ST_P_RD,
        ST_P_EX,
        ST_C_RD,
        ST_C_EX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic start_ack;
        logic min_step;
        logic ins_rd;
        logic ins_wr;
        logic ins_final;
        logic v_rd;
        logic v_ex;
        logic p_rd;
        logic p_ex;
        logic c_rd;
        logic c_ex;
        logic scan_reset;
        logic emit;
        logic emit_none;
        logic ack_mode;
    } cmd_t;

    typedef struct packed {
        logic [2:0] typ;
        logic       ack_valid;
        logic       full;
        logic       min_done;
        logic       ins_done;
        logic       ins_after;
        logic       scan_done;
        logic       out_busy;
    } status_t;
endpackage
`default_nettype wire

/* sv/omsn_datapath.sv */
`default_nettype none
module omsn_datapath
    import omsn_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    parameter int SEMS = SEMS_DEF,
    parameter int QUEUE_DEPTH = QDEPTH_DEF
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  item,
    input  wire logic [2:0] node_id,
    input  wire cmd_t      cmd,
    output status_t        status,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(NODES + 1);
    localparam int SW = (SEMS > 1) ? $clog2(SEMS) : 1;

    in_item_t    it_reg;
    logic [31:0] local_time_reg;
    logic [31:0] m_reg;
    logic [31:0] last_ack_reg [NODES];
    logic [7:0]  sem_reg [SEMS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] rd_reg;
    logic [CW-1:0] wr_reg;
    logic [NW-1:0] ni_reg;
    logic [31:0] oldest_reg;
    logic [6:0]  grants_reg;
    logic [QUEUE_DEPTH-1:0] gone_reg;
    logic        stop_reg;
    entry_t      mem [QUEUE_DEPTH];
    entry_t      rdata_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;
    out_item_t   out_next;

    logic [31:0] m_c;
    logic [31:0] inc_m;
    logic [31:0] inc2;
    entry_t      new_e;
    logic        after;
    logic        rd_en;
    logic [QW-1:0] rd_addr;
    logic        wr_en;
    logic [QW-1:0] wr_addr;
    entry_t      wr_data;
    logic [SW-1:0] si;
    logic        sem_ok;

    assign m_c = (local_time_reg > item.msg_time) ? local_time_reg : item.msg_time;
    assign inc_m = (m_c == 32'hFFFF_FFFF) ? m_c : m_c + 32'd1;
    assign inc2 = (local_time_reg == 32'hFFFF_FFFF) ? local_time_reg
                                                    : local_time_reg + 32'd1;
    assign new_e = '{sender: it_reg.sender_id, stamp: it_reg.msg_time,
                     op: it_reg.req_type[1:0], sem: it_reg.sem_index};
    assign after = (rdata_reg.stamp != new_e.stamp) ? (rdata_reg.stamp > new_e.stamp)
                                                    : (rdata_reg.sender > new_e.sender);
    assign si = rdata_reg.sem[SW-1:0];
    assign sem_ok = ({28'd0, rdata_reg.sem} < SEMS);

    always_comb
    begin
        rd_en = cmd.ins_rd | cmd.v_rd | cmd.p_rd | cmd.c_rd;
        rd_addr = cmd.ins_rd ? QW'(pos_reg - CW'(1)) : rd_reg[QW-1:0];
        wr_en = 1'b0;
        wr_addr = QW'(pos_reg);
        wr_data = rdata_reg;
        if (cmd.ins_wr && after)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.ins_final)
        begin
            wr_en = 1'b1;
            wr_data = new_e;
        end
        else if (cmd.c_ex && !gone_reg[QW'(rd_reg - CW'(1))])
        begin
            wr_en = 1'b1;
            wr_addr = wr_reg[QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        out_next = '0;
        if (cmd.ack_mode)
        begin
            out_next.out_kind = 1'b1;
            out_next.out_sender = node_id;
            out_next.grant_count = grants_reg;
        end
        else if (it_reg.req_type == REQ_RP || it_reg.req_type == REQ_RV)
        begin
            out_next.out_op = (it_reg.req_type == REQ_RP) ? OP_P : OP_V;
            out_next.out_sender = it_reg.sender_id;
            out_next.out_time = m_reg;
            out_next.out_sem = it_reg.sem_index;
        end
        else
        begin
            out_next.out_op = OP_ACK;
            out_next.out_sender = node_id;
            out_next.out_time = m_reg;
            out_next.queue_overflow = (count_reg >= CW'(QUEUE_DEPTH)) && !cmd.emit_none;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_time_reg <= '0;
            for (int i = 0; i < NODES; i++) last_ack_reg[i] <= '0;
            for (int i = 0; i < SEMS; i++) sem_reg[i] <= 8'd1;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            pos_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            ni_reg <= '0;
            grants_reg <= '0;
            gone_reg <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                it_reg <= item;
                m_reg <= m_c;
                local_time_reg <= inc_m;
                pos_reg <= count_reg;
            end
            if (cmd.start_ack)
            begin
                last_ack_reg[it_reg.sender_id - 3'd1] <= it_reg.msg_time;
                oldest_reg <= it_reg.msg_time;
                ni_reg <= '0;
                grants_reg <= '0;
                gone_reg <= '0;
            end
            if (cmd.min_step)
            begin
                if ((ni_reg + NW'(1) != NW'(node_id)) &&
                    (last_ack_reg[ni_reg[NW-1:0]] < oldest_reg))
                    oldest_reg <= last_ack_reg[ni_reg];
                ni_reg <= ni_reg + NW'(1);
            end
            if (cmd.ins_wr)
            begin
                if (after)
                    pos_reg <= pos_reg - CW'(1);
            end
            if (cmd.ins_final)
                count_reg <= count_reg + CW'(1);
            if (cmd.scan_reset)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
                stop_reg <= 1'b0;
            end
            if (cmd.v_rd || cmd.p_rd || cmd.c_rd)
                rd_reg <= rd_reg + CW'(1);
            if (cmd.v_ex)
            begin
                if (rdata_reg.stamp >= oldest_reg)
                    stop_reg <= 1'b1;
                else if (rdata_reg.op == OP_V)
                begin
                    gone_reg[QW'(rd_reg - CW'(1))] <= 1'b1;
                    if (sem_ok && sem_reg[si] != 8'hFF)
                        sem_reg[si] <= sem_reg[si] + 8'd1;
                end
            end
            if (cmd.p_ex)
            begin
                if (rdata_reg.stamp >= oldest_reg)
                    stop_reg <= 1'b1;
                else if (rdata_reg.op == OP_P)
                begin
                    if (!sem_ok)
                        gone_reg[QW'(rd_reg - CW'(1))] <= 1'b1;
                    else if (sem_reg[si] != 8'd0)
                    begin
                        gone_reg[QW'(rd_reg - CW'(1))] <= 1'b1;
                        sem_reg[si] <= sem_reg[si] - 8'd1;
                        if (rdata_reg.sender == node_id && grants_reg != 7'd127)
                            grants_reg <= grants_reg + 7'd1;
                    end
                end
            end
            if (cmd.c_ex && !gone_reg[QW'(rd_reg - CW'(1))])
                wr_reg <= wr_reg + CW'(1);
            if (cmd.emit && cmd.ack_mode)
                count_reg <= wr_reg;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= out_next;
                // acks advance the clock only once
                if (!cmd.ack_mode)
                    local_time_reg <= inc2;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // emit_none flags a P/V that was queued this item (count already bumped)
    always_comb
    begin
        status.typ = it_reg.req_type;
        status.ack_valid = (it_reg.sender_id != node_id) && (it_reg.sender_id != 3'd0) &&
                           ({29'd0, it_reg.sender_id} <= NODES);
        status.full = (count_reg >= CW'(QUEUE_DEPTH));
        status.min_done = (ni_reg == NW'(NODES));
        status.ins_done = (pos_reg == '0);
        status.ins_after = after;
        status.scan_done = stop_reg || (rd_reg == count_reg);
        status.out_busy = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;
endmodule
`default_nettype wire

/* sv/omsn_ctrl.sv */
`default_nettype none
module omsn_ctrl
    import omsn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;
    logic queued_reg, queued_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            queued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            queued_reg <= queued_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        queued_next = queued_reg;
        cmd = '0;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                queued_next = 1'b0;
                priority if (status.typ == REQ_ACK)
                begin
                    if (status.ack_valid)
                    begin
                        cmd.start_ack = 1'b1;
                        state_next = ST_MIN;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else if (status.typ == REQ_P || status.typ == REQ_V)
                begin
                    if (status.full)
                        state_next = ST_OUT;
                    else if (status.ins_done)
                    begin
                        cmd.ins_final = 1'b1;
                        queued_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.ins_rd = 1'b1;
                        state_next = ST_INS_WR;
                    end
                end
                else if (status.typ == REQ_RP || status.typ == REQ_RV)
                    state_next = ST_OUT;
                else
                    state_next = ST_IDLE;
            end
            ST_INS_RD:
            begin
                if (status.ins_done)
                begin
                    cmd.ins_final = 1'b1;
                    queued_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                if (status.ins_after)
                    state_next = ST_INS_RD;
                else
                begin
                    // entry is not after the new one: place the new one above it
                    cmd.ins_final = 1'b1;
                    queued_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_MIN:
            begin
                cmd.ack_mode = 1'b1;
                if (status.min_done)
                begin
                    cmd.scan_reset = 1'b1;
                    state_next = ST_V_RD;
                end
                else
                    cmd.min_step = 1'b1;
            end
            ST_V_RD:
            begin
                cmd.ack_mode = 1'b1;
                if (status.scan_done)
                begin
                    cmd.scan_reset = 1'b1;
                    state_next = ST_P_RD;
                end
                else
                begin
                    cmd.v_rd = 1'b1;
                    state_next = ST_V_EX;
                end
            end
            ST_V_EX:
            begin
                cmd.ack_mode = 1'b1;
                cmd.v_ex = 1'b1;
                state_next = ST_V_RD;
            end
            ST_P_RD:
            begin
                cmd.ack_mode = 1'b1;
                if (status.scan_done)
                begin
                    cmd.scan_reset = 1'b1;
                    state_next = ST_C_RD;
                end
                else
                begin
                    cmd.p_rd = 1'b1;
                    state_next = ST_P_EX;
                end
            end
            ST_P_EX:
            begin
                cmd.ack_mode = 1'b1;
                cmd.p_ex = 1'b1;
                state_next = ST_P_RD;
            end
            ST_C_RD:
            begin
                cmd.ack_mode = 1'b1;
                if (status.scan_done)
                    state_next = ST_OUT;
                else
                begin
                    cmd.c_rd = 1'b1;
                    state_next = ST_C_EX;
                end
            end
            ST_C_EX:
            begin
                cmd.ack_mode = 1'b1;
                cmd.c_ex = 1'b1;
                state_next = ST_C_RD;
            end
            ST_OUT:
            begin
                cmd.ack_mode = (status.typ == REQ_ACK);
                cmd.emit_none = queued_reg;
                if (!status.out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/ordered_multicast_semaphore_node.sv */
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_item_t
// out      output     out_valid / out_stall  out_item_t
// cfg      input      APB write, pready high node_id at address 0
// Each item is handled whole before the next is taken; an insert walks the
// queue from its tail, and an ack walks it in a V pass, a P pass and a
// compaction pass through the one read port of the queue memory.
// Reset clears clock, ack times and queue fill count, and sets every semaphore to 1.
// A stalled result blocks the next item only at its own output step.
module ordered_multicast_semaphore_node
    import omsn_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    parameter int SEMS = SEMS_DEF,
    parameter int QUEUE_DEPTH = QDEPTH_DEF
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    logic [2:0] node_id_reg;
    cmd_t cmd;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_id_reg <= 3'd1;
        else if (psel && penable && pwrite && paddr == ADDR_NODE_ID)
            node_id_reg <= pwdata[2:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NODE_ID) ? {29'd0, node_id_reg} : 32'd0;

    omsn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .status(status), .cmd(cmd)
    );

    omsn_datapath #(.NODES(NODES), .SEMS(SEMS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .item(in_item), .node_id(node_id_reg),
        .cmd(cmd), .status(status), .out_valid(out_valid),
        .out_stall(out_stall), .out_item(out_item)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cmd.load_item) else $error("load while busy");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid) else $error("emit lost");
    a_ovf_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.queue_overflow |-> !out_item.out_kind)
        else $error("overflow on grant");
`endif
endmodule
`default_nettype wire

/* tb/omsn_checker.sv */
`timescale 1ns / 1ps
module omsn_checker
    import omsn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire in_item_t    in_item,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire out_item_t   out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               errors,
    output int               outstanding
);
    logic [2:0]  node;
    logic [31:0] lclock;
    logic [31:0] ack_time [1:NODES_DEF];
    logic [7:0]  sem_cnt [SEMS_DEF];
    entry_t      waiting_ops [$];
    out_item_t   expected_results [$];

    assign outstanding = expected_results.size();

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function automatic bit later_key(input entry_t a, input entry_t b);
        if (a.stamp != b.stamp)
            return a.stamp > b.stamp;
        return a.sender > b.sender;
    endfunction

    // apply due V ops, then due P ops; return own grants
    function automatic logic [6:0] settle_due(input logic [31:0] lim);
        bit          gone [QDEPTH_DEF];
        int          n;
        logic [6:0]  grants;
        entry_t      e;
        grants = '0;
        n = 0;
        foreach (gone[i])
            gone[i] = 0;
        while (n < waiting_ops.size() && waiting_ops[n].stamp < lim)
            n++;
        for (int i = 0; i < n; i++) begin
            e = waiting_ops[i];
            if (e.op == OP_V) begin
                gone[i] = 1;
                if (e.sem < SEMS_DEF && sem_cnt[e.sem] < 8'd255)
                    sem_cnt[e.sem]++;
            end
        end
        for (int i = 0; i < n; i++) begin
            e = waiting_ops[i];
            if (e.op != OP_P)
                continue;
            if (e.sem >= SEMS_DEF) begin
                gone[i] = 1;
            end else if (sem_cnt[e.sem] > 0) begin
                gone[i] = 1;
                sem_cnt[e.sem]--;
                if (e.sender == node && grants < 7'd127)
                    grants++;
            end
        end
        for (int i = waiting_ops.size() - 1; i >= 0; i--)
            if (gone[i])
                waiting_ops.delete(i);
        return grants;
    endfunction

    task automatic predict_request(input in_item_t it);
        logic [31:0] m;
        logic [31:0] oldest;
        out_item_t   r;
        entry_t      e;
        int          pos;
        m = (lclock > it.msg_time) ? lclock : it.msg_time;
        lclock = sat_inc(m);
        r = '0;
        case (it.req_type)
            REQ_RP, REQ_RV: begin
                lclock = sat_inc(lclock);
                r.out_op = (it.req_type == REQ_RP) ? OP_P : OP_V;
                r.out_sender = it.sender_id;
                r.out_time = m;
                r.out_sem = it.sem_index;
                expected_results.push_back(r);
            end
            REQ_P, REQ_V: begin
                if (waiting_ops.size() >= QDEPTH_DEF) begin
                    r.queue_overflow = 1'b1;
                end else begin
                    e.sender = it.sender_id;
                    e.stamp = it.msg_time;
                    e.op = (it.req_type == REQ_P) ? OP_P : OP_V;
                    e.sem = it.sem_index;
                    pos = waiting_ops.size();
                    while (pos > 0 && later_key(waiting_ops[pos - 1], e))
                        pos--;
                    waiting_ops.insert(pos, e);
                end
                lclock = sat_inc(lclock);
                r.out_op = OP_ACK;
                r.out_sender = node;
                r.out_time = m;
                expected_results.push_back(r);
            end
            REQ_ACK: begin
                if (it.sender_id != node && it.sender_id != 0 && it.sender_id <= NODES_DEF) begin
                    ack_time[it.sender_id] = it.msg_time;
                    oldest = it.msg_time;
                    for (int i = 1; i <= NODES_DEF; i++)
                        if (i != node && ack_time[i] < oldest)
                            oldest = ack_time[i];
                    r.out_kind = 1'b1;
                    r.out_sender = node;
                    r.grant_count = settle_due(oldest);
                    expected_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
        if (exp_v === act_v)
            return 0;
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t x;
        if (!rst_n) begin
            node = 3'd1;
            lclock = '0;
            foreach (ack_time[i])
                ack_time[i] = '0;
            foreach (sem_cnt[i])
                sem_cnt[i] = 8'd1;
            waiting_ops.delete();
            expected_results.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_NODE_ID)
                node = pwdata[2:0];
            if (in_valid && !in_stall)
                predict_request(in_item);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", out_item);
                    errors++;
                end else begin
                    x = expected_results.pop_front();
                    errors += field_bad("out_kind", x.out_kind, out_item.out_kind)
                            + field_bad("out_op", x.out_op, out_item.out_op)
                            + field_bad("out_sender", x.out_sender, out_item.out_sender)
                            + field_bad("out_time", x.out_time, out_item.out_time)
                            + field_bad("out_sem", x.out_sem, out_item.out_sem)
                            + field_bad("grant_count", x.grant_count, out_item.grant_count)
                            + field_bad("queue_overflow", x.queue_overflow,
                                        out_item.queue_overflow);
                end
            end
        end
    end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import omsn_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          outstanding;
    int          cycles;
    int          burst_left;
    int unsigned tbase;

    ordered_multicast_semaphore_node uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    omsn_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .errors(errors), .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall: one of four randomly picked modes
    always @(negedge clk) begin
        int mode;
        if (cycles % 64 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (cycles % 16) < 5;
        endcase
    end

    task automatic send(input logic [2:0] typ, input logic [2:0] snd,
                        input logic [31:0] t, input logic [3:0] sem);
        @(negedge clk);
        in_valid = 1'b1;
        in_item = '{req_type: typ, sender_id: snd, msg_time: t, sem_index: sem};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic go_quiet();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_node_id(input logic [2:0] id);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_NODE_ID;
        pwdata = {29'd0, id};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic logic [31:0] near_time();
        return tbase + $urandom_range(0, 8);
    endfunction

    // ack round from every node so that queued ops fall due
    task automatic ack_all(input logic [31:0] t);
        for (int n = 1; n <= NODES_DEF; n++)
            send(REQ_ACK, n[2:0], t, 4'd0);
    endtask

    task automatic random_traffic(input int count, input bit wild);
        int          pick;
        logic [31:0] t;
        for (int k = 0; k < count; k++) begin
            tbase += $urandom_range(0, 3);
            pick = $urandom_range(0, 99);
            t = near_time();
            if (pick < 40)
                send($urandom_range(0, 1) ? REQ_P : REQ_V, $urandom_range(1, 5), t,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
                                                 : $urandom_range(0, 9));
            else if (pick < 58)
                send($urandom_range(0, 1) ? REQ_RP : REQ_RV, $urandom_range(1, 5), t,
                     $urandom_range(0, 15));
            else if (pick < 90)
                send(REQ_ACK, $urandom_range(1, 5), t + $urandom_range(0, 10), 4'd0);
            else
                send($urandom_range(0, 7), $urandom_range(0, 7),
                     wild ? $urandom : t, $urandom_range(0, 15));
        end
    endtask

    initial begin
        logic [2:0] ids [5] = '{3'd1, 3'd5, 3'd3, 3'd2, 3'd4};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        burst_left = 0;
        tbase = 20;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: requests, ops, ignored inputs, acks
        send(REQ_RP, 3'd1, 32'd0, 4'd0);
        send(REQ_RV, 3'd5, 32'd2, 4'd9);
        send(REQ_RP, 3'd4, 32'd1, 4'd15);
        send(REQ_P, 3'd1, 32'd5, 4'd0);
        send(REQ_P, 3'd1, 32'd5, 4'd0);
        send(REQ_V, 3'd2, 32'd3, 4'd15);
        send(REQ_P, 3'd3, 32'd4, 4'd12);
        send(REQ_V, 3'd4, 32'd6, 4'd0);
        send(REQ_ACK, 3'd1, 32'd50, 4'd0);
        send(REQ_ACK, 3'd0, 32'd50, 4'd0);
        send(REQ_ACK, 3'd7, 32'd50, 4'd0);
        send(3'd5, 3'd2, 32'd7, 4'd3);
        send(3'd6, 3'd6, 32'd8, 4'd7);
        send(3'd7, 3'd7, 32'd9, 4'd15);
        send(REQ_ACK, 3'd2, 32'd0, 4'd0);
        ack_all(32'd10);
        send(REQ_ACK, 3'd3, 32'd0, 4'd0);

        foreach (ids[p]) begin
            go_quiet();
            write_node_id(ids[p]);
            if (p == 1) begin
                // fill the queue past its depth, then drain it
                for (int k = 0; k < QDEPTH_DEF + 4; k++)
                    send($urandom_range(0, 1) ? REQ_P : REQ_V, $urandom_range(1, 5),
                         near_time(), $urandom_range(0, 9));
                tbase += 20;
                ack_all(tbase);
            end
            random_traffic(83, 1'b0);
            tbase += 20;
            ack_all(tbase);
        end

        // wide timestamps last: the clock saturates and stays there
        random_traffic(10, 1'b1);
        send(REQ_P, 3'd5, 32'hFFFF_FFFE, 4'd1);
        send(REQ_RV, 3'd2, 32'hFFFF_FFFF, 4'd1);
        ack_all(32'hFFFF_FFFF);
        go_quiet();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
